/* hw/rtl/x86div_pkg.sv */
// ----------------------------------------------------------------------------
// x86div_pkg: shared types for the pipelined 64-by-32 divider
// Request type codes, the per-item flag group and the fixed field width.
// ----------------------------------------------------------------------------
package x86div_pkg;

  // Width of every data field on the channels.
  localparam int unsigned FieldBits = 32;

  typedef enum logic {
    REQ_UNSIGNED = 1'b0,
    REQ_SIGNED   = 1'b1
  } req_type_e;

  // Flags that travel with an item down the pipeline.
  typedef struct packed {
    logic err;   // zero divisor or quotient overflow already known
    logic nneg;  // dividend is negative (signed divide)
    logic qneg;  // quotient must be negated (signed divide)
    logic sgn;   // signed divide
  } x86div_flags_t;

endpackage

/* hw/rtl/x86div_if.sv */
// ----------------------------------------------------------------------------
// x86div_if: request and response channels of the divider
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface x86div_req_if
  import x86div_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [FieldBits-1:0] dividend_high;
  logic [FieldBits-1:0] dividend_low;
  logic [FieldBits-1:0] divisor;

  modport source (output valid, req_type, dividend_high, dividend_low, divisor,
                  input  ready);
  modport sink   (input  valid, req_type, dividend_high, dividend_low, divisor,
                  output ready);
endinterface

interface x86div_rsp_if
  import x86div_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [FieldBits-1:0] quotient;
  logic [FieldBits-1:0] remainder;
  logic                 divide_error;

  modport source (output valid, quotient, remainder, divide_error,
                  input  ready);
  modport sink   (input  valid, quotient, remainder, divide_error,
                  output ready);
endinterface

/* hw/rtl/x86div_prep.sv */
// ----------------------------------------------------------------------------
// x86div_prep: operand preparation stage
// Takes magnitudes of dividend and divisor and flags a zero divisor or an
// overflow that the high dividend word alone already reveals.
// ----------------------------------------------------------------------------
module x86div_prep
  import x86div_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_type_i,
  input  logic [FieldBits-1:0] dividend_high_i,
  input  logic [FieldBits-1:0] dividend_low_i,
  input  logic [FieldBits-1:0] divisor_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WORD_BITS-1:0] rem_o,
  output logic [WORD_BITS-1:0] sh_o,
  output logic [WORD_BITS-1:0] dmag_o,
  output logic [WORD_BITS-1:0] hi_o,
  output logic [WORD_BITS-1:0] lo_o,
  output x86div_flags_t        flags_o
);

  localparam int unsigned TwoBits = 2 * WORD_BITS;

  logic [WORD_BITS-1:0] hi, lo, d, dmag;
  logic [TwoBits-1:0]   num, nmag;
  logic                 sgn, nneg, dneg;
  x86div_flags_t        flags_d, flags_q;
  logic                 valid_q;
  logic [WORD_BITS-1:0] rem_q, sh_q, dmag_q, hi_q, lo_q;

  always_comb begin
    hi   = dividend_high_i[WORD_BITS-1:0];
    lo   = dividend_low_i[WORD_BITS-1:0];
    d    = divisor_i[WORD_BITS-1:0];
    num  = {hi, lo};
    sgn  = (req_type_i == REQ_SIGNED);
    nneg = sgn & num[TwoBits-1];
    dneg = sgn & d[WORD_BITS-1];
    nmag = nneg ? TwoBits'(~num + TwoBits'(1)) : num;
    dmag = dneg ? WORD_BITS'(~d + WORD_BITS'(1)) : d;
    // A high magnitude word at or above the divisor means the quotient needs
    // more than a word, so the iterations below can assume rem < divisor.
    flags_d.err  = (d == '0) || (nmag[TwoBits-1:WORD_BITS] >= dmag);
    flags_d.nneg = nneg;
    flags_d.qneg = nneg ^ dneg;
    flags_d.sgn  = sgn;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rem_q   <= nmag[TwoBits-1:WORD_BITS];
      sh_q    <= nmag[WORD_BITS-1:0];
      dmag_q  <= dmag;
      hi_q    <= hi;
      lo_q    <= lo;
      flags_q <= flags_d;
    end
  end

  assign out_valid_o = valid_q;
  assign rem_o       = rem_q;
  assign sh_o        = sh_q;
  assign dmag_o      = dmag_q;
  assign hi_o        = hi_q;
  assign lo_o        = lo_q;
  assign flags_o     = flags_q;

endmodule

/* hw/rtl/x86div_step.sv */
// ----------------------------------------------------------------------------
// x86div_step: one restoring-division iteration stage
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit in at the bottom.
// ----------------------------------------------------------------------------
module x86div_step
  import x86div_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [WORD_BITS-1:0] rem_i,
  input  logic [WORD_BITS-1:0] sh_i,
  input  logic [WORD_BITS-1:0] dmag_i,
  input  logic [WORD_BITS-1:0] hi_i,
  input  logic [WORD_BITS-1:0] lo_i,
  input  x86div_flags_t        flags_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WORD_BITS-1:0] rem_o,
  output logic [WORD_BITS-1:0] sh_o,
  output logic [WORD_BITS-1:0] dmag_o,
  output logic [WORD_BITS-1:0] hi_o,
  output logic [WORD_BITS-1:0] lo_o,
  output x86div_flags_t        flags_o
);

  logic [WORD_BITS:0]   trial, diff;
  logic                 qbit;
  logic [WORD_BITS-1:0] rem_d, sh_d;
  logic                 valid_q;
  logic [WORD_BITS-1:0] rem_q, sh_q, dmag_q, hi_q, lo_q;
  x86div_flags_t        flags_q;

  always_comb begin
    trial = {rem_i, sh_i[WORD_BITS-1]};
    diff  = trial - {1'b0, dmag_i};
    qbit  = (trial >= {1'b0, dmag_i});
    rem_d = qbit ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
    sh_d  = {sh_i[WORD_BITS-2:0], qbit};
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rem_q   <= rem_d;
      sh_q    <= sh_d;
      dmag_q  <= dmag_i;
      hi_q    <= hi_i;
      lo_q    <= lo_i;
      flags_q <= flags_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rem_o       = rem_q;
  assign sh_o        = sh_q;
  assign dmag_o      = dmag_q;
  assign hi_o        = hi_q;
  assign lo_o        = lo_q;
  assign flags_o     = flags_q;

endmodule

/* hw/rtl/x86div_fix.sv */
// ----------------------------------------------------------------------------
// x86div_fix: sign correction and result register
// Applies the result signs, checks the signed quotient range and selects the
// original words when a divide error is raised.
// ----------------------------------------------------------------------------
module x86div_fix
  import x86div_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [WORD_BITS-1:0] rem_i,
  input  logic [WORD_BITS-1:0] quo_i,
  input  logic [WORD_BITS-1:0] hi_i,
  input  logic [WORD_BITS-1:0] lo_i,
  input  x86div_flags_t        flags_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [FieldBits-1:0] quotient_o,
  output logic [FieldBits-1:0] remainder_o,
  output logic                 divide_error_o
);

  logic                 range_err, err;
  logic [WORD_BITS-1:0] q_fix, r_fix;
  logic                 valid_q, err_q;
  logic [FieldBits-1:0] quo_q, rem_q;

  always_comb begin
    // A negative quotient may reach the most negative word; a positive one
    // must stay below it.
    if (!flags_i.sgn) begin
      range_err = 1'b0;
    end else if (flags_i.qneg) begin
      range_err = quo_i[WORD_BITS-1] && (quo_i[WORD_BITS-2:0] != '0);
    end else begin
      range_err = quo_i[WORD_BITS-1];
    end
    err   = flags_i.err || range_err;
    q_fix = flags_i.qneg ? WORD_BITS'(~quo_i + WORD_BITS'(1)) : quo_i;
    r_fix = flags_i.nneg ? WORD_BITS'(~rem_i + WORD_BITS'(1)) : rem_i;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      quo_q <= FieldBits'(err ? lo_i : q_fix);
      rem_q <= FieldBits'(err ? hi_i : r_fix);
      err_q <= err;
    end
  end

  assign out_valid_o    = valid_q;
  assign quotient_o     = quo_q;
  assign remainder_o    = rem_q;
  assign divide_error_o = err_q;

endmodule

/* hw/rtl/x86_divide_64_by_32.sv */
// ----------------------------------------------------------------------------
// x86_divide_64_by_32: pipelined double-word-by-word integer divider
// A request carries a high and a low dividend word, a divisor and a request
// type (unsigned or signed divide). Each response carries the quotient, the
// remainder and a divide error flag; on an error the low and high words come
// back unchanged in the quotient and remainder fields.
//
// A request transfers on req_i when valid and ready are high, a response on
// rsp_o likewise. The pipeline is one preparation stage, WORD_BITS restoring
// iteration stages (one quotient bit each) and a sign correction stage that
// holds the response. One request is taken every cycle while the pipeline
// is not full; a receiver stall fills the stages and then holds req_i off.
//
// When the receiver stalls, items stop in place stage by stage; ready goes
// low only once every stage holds an item, so bubbles are squeezed out and
// nothing is lost or repeated. Reset clears all stage valid bits; the data
// registers are not reset.
// ----------------------------------------------------------------------------
module x86_divide_64_by_32
  import x86div_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  x86div_req_if.sink   req_i,
  x86div_rsp_if.source rsp_o
);

  // Index 0 is the preparation register, index k the k-th iteration stage.
  logic                 valid  [0:WORD_BITS];
  logic                 ready  [0:WORD_BITS];
  logic [WORD_BITS-1:0] rem    [0:WORD_BITS];
  logic [WORD_BITS-1:0] sh     [0:WORD_BITS];
  logic [WORD_BITS-1:0] dmag   [0:WORD_BITS];
  logic [WORD_BITS-1:0] hi     [0:WORD_BITS];
  logic [WORD_BITS-1:0] lo     [0:WORD_BITS];
  x86div_flags_t        flags  [0:WORD_BITS];
  logic                 fix_ready;

  x86div_prep #(
    .WORD_BITS(WORD_BITS)
  ) u_prep (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_i.valid),
    .in_ready_o     (req_i.ready),
    .req_type_i     (req_i.req_type),
    .dividend_high_i(req_i.dividend_high),
    .dividend_low_i (req_i.dividend_low),
    .divisor_i      (req_i.divisor),
    .out_valid_o    (valid[0]),
    .out_ready_i    (ready[0]),
    .rem_o          (rem[0]),
    .sh_o           (sh[0]),
    .dmag_o         (dmag[0]),
    .hi_o           (hi[0]),
    .lo_o           (lo[0]),
    .flags_o        (flags[0])
  );

  for (genvar k = 1; k <= WORD_BITS; k++) begin : g_step
    x86div_step #(
      .WORD_BITS(WORD_BITS)
    ) u_step (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (valid[k-1]),
      .in_ready_o (ready[k-1]),
      .rem_i      (rem[k-1]),
      .sh_i       (sh[k-1]),
      .dmag_i     (dmag[k-1]),
      .hi_i       (hi[k-1]),
      .lo_i       (lo[k-1]),
      .flags_i    (flags[k-1]),
      .out_valid_o(valid[k]),
      .out_ready_i(ready[k]),
      .rem_o      (rem[k]),
      .sh_o       (sh[k]),
      .dmag_o     (dmag[k]),
      .hi_o       (hi[k]),
      .lo_o       (lo[k]),
      .flags_o    (flags[k])
    );
  end

  assign ready[WORD_BITS] = fix_ready;

  x86div_fix #(
    .WORD_BITS(WORD_BITS)
  ) u_fix (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (valid[WORD_BITS]),
    .in_ready_o    (fix_ready),
    .rem_i         (rem[WORD_BITS]),
    .quo_i         (sh[WORD_BITS]),
    .hi_i          (hi[WORD_BITS]),
    .lo_i          (lo[WORD_BITS]),
    .flags_i       (flags[WORD_BITS]),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .quotient_o    (rsp_o.quotient),
    .remainder_o   (rsp_o.remainder),
    .divide_error_o(rsp_o.divide_error)
  );

endmodule
